FILE: sv/utcd_pkg.sv
`default_nettype none

package utcd_pkg;

    // Datapath operation codes
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_DIV_DAY  = 3'd2;
    localparam logic [2:0] OP_DIV_HOUR = 3'd3;
    localparam logic [2:0] OP_DIV_MIN  = 3'd4;
    localparam logic [2:0] OP_YEAR     = 3'd5;
    localparam logic [2:0] OP_MONTH    = 3'd6;
    localparam logic [2:0] OP_PUBLISH  = 3'd7;

    // Divisors for the remainder steps
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    // Reciprocals for the quotient steps: days as (secs >> 7) * DAY_RECIP >> 35,
    // hours as tod * HOUR_RECIP >> 29, minutes as rem * MIN_RECIP >> 18
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;

    // Calendar walk start values
    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [6:0]  BASE_YEAR_100 = 7'd70;
    localparam logic [8:0]  BASE_YEAR_400 = 9'd370;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    // Zone offset register, held as seconds (reset: +8 hours)
    localparam logic signed [16:0] ZONE_SECS_RESET = 17'sd28800;
    localparam logic signed [16:0] ZONE_SECS_UNIT  = 17'sd3600;

    typedef struct packed {
        logic [2:0] op;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_status;

    // Days in month, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1: len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: sv/utcd_ctrl.sv
`default_nettype none

module utcd_ctrl
    import utcd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DAY    = 3'd1;
    localparam logic [2:0] ST_HOUR   = 3'd2;
    localparam logic [2:0] ST_MIN    = 3'd3;
    localparam logic [2:0] ST_YEAR   = 3'd4;
    localparam logic [2:0] ST_MONTH  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // Sequence the conversion phases; each division takes a quotient and a remainder step
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_stall;
        o_cmd       = '{op: OP_NONE, last: !r_cnt};
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DAY;
                    n_cnt    = 1'b1;
                end
            end
            ST_DAY: begin
                o_cmd.op = OP_DIV_DAY;
                if (o_cmd.last) begin
                    n_state = ST_HOUR;
                    n_cnt   = 1'b1;
                end else begin
                    n_cnt = 1'b0;
                end
            end
            ST_HOUR: begin
                o_cmd.op = OP_DIV_HOUR;
                if (o_cmd.last) begin
                    n_state = ST_MIN;
                    n_cnt   = 1'b1;
                end else begin
                    n_cnt = 1'b0;
                end
            end
            ST_MIN: begin
                o_cmd.op = OP_DIV_MIN;
                if (o_cmd.last) begin
                    n_state = ST_YEAR;
                end else begin
                    n_cnt = 1'b0;
                end
            end
            ST_YEAR: begin
                o_cmd.op = OP_YEAR;
                if (i_status.year_done) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                o_cmd.op = OP_MONTH;
                if (i_status.month_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hand off once the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/utcd_datapath.sv
`default_nettype none

module utcd_datapath
    import utcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_epoch_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    logic signed [16:0] r_zone_secs;
    logic [32:0]        r_rem;
    logic [15:0]        r_quo;
    logic [15:0]        r_days;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [11:0]        r_year;
    logic [6:0]         r_y100;
    logic [8:0]         r_y400;
    logic [3:0]         r_mon;
    logic [11:0]        r_out_year;
    logic [3:0]         r_out_month;
    logic [4:0]         r_out_day;
    logic [4:0]         r_out_hour;
    logic [5:0]         r_out_min;
    logic [5:0]         r_out_sec;

    logic signed [16:0] w_zone_secs;
    logic signed [33:0] w_sum;
    logic [32:0]        w_start;
    logic [16:0]        w_div_base;
    logic [50:0]        w_day_prod;
    logic [33:0]        w_hour_prod;
    logic [23:0]        w_min_prod;
    logic [15:0]        w_quo_est;
    logic [32:0]        w_div_back;
    logic               w_leap;
    logic [8:0]         w_ylen;
    logic [4:0]         w_mlen;

    // Offset in hours to seconds, taken at the register write
    assign w_zone_secs = $signed(i_cfg_data) * ZONE_SECS_UNIT;

    // Shift into local time and clamp below the epoch
    assign w_sum   = $signed({2'b00, i_epoch_seconds})
                   + $signed({{17{r_zone_secs[16]}}, r_zone_secs});
    assign w_start = w_sum[33] ? 33'd0 : w_sum[32:0];

    // Quotient by reciprocal multiplication; days drop the factor 128 first
    assign w_day_prod  = {25'd0, r_rem[32:7]} * {25'd0, DAY_RECIP};
    assign w_hour_prod = {17'd0, r_rem[16:0]} * {16'd0, HOUR_RECIP};
    assign w_min_prod  = {12'd0, r_rem[11:0]} * {11'd0, MIN_RECIP};

    always_comb begin
        case (i_cmd.op)
            OP_DIV_DAY: begin
                w_div_base = SECS_PER_DAY;
                w_quo_est  = w_day_prod[50:35];
            end
            OP_DIV_HOUR: begin
                w_div_base = SECS_PER_HOUR;
                w_quo_est  = {11'd0, w_hour_prod[33:29]};
            end
            default: begin
                w_div_base = SECS_PER_MIN;
                w_quo_est  = {10'd0, w_min_prod[23:18]};
            end
        endcase
    end

    // Quotient times divisor, taken off the remainder in the second step
    assign w_div_back = {17'd0, r_quo} * {16'd0, w_div_base};

    // Leap year from the running year residues
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_mon, w_leap);

    assign o_status.year_done  = (r_days < {7'd0, w_ylen});
    assign o_status.month_done = (r_days < {11'd0, w_mlen}) || (r_mon >= LAST_MONTH);

    // Hold the zone offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_secs <= ZONE_SECS_RESET;
        end else if (i_cfg_we) begin
            r_zone_secs <= w_zone_secs;
        end
    end

    // Divide, then walk years and months
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_rem <= w_start;
                r_quo <= 16'd0;
            end
            OP_DIV_DAY, OP_DIV_HOUR, OP_DIV_MIN: begin
                if (i_cmd.last) begin
                    r_rem <= r_rem - w_div_back;
                end else begin
                    r_quo <= w_quo_est;
                end
                if (i_cmd.last && i_cmd.op == OP_DIV_DAY) begin
                    r_days <= r_quo;
                    r_year <= BASE_YEAR;
                    r_y100 <= BASE_YEAR_100;
                    r_y400 <= BASE_YEAR_400;
                    r_mon  <= 4'd0;
                end
                if (i_cmd.last && i_cmd.op == OP_DIV_HOUR) begin
                    r_hour <= r_quo[4:0];
                end
                if (i_cmd.last && i_cmd.op == OP_DIV_MIN) begin
                    r_min <= r_quo[5:0];
                end
            end
            OP_YEAR: begin
                if (!o_status.year_done) begin
                    r_days <= r_days - {7'd0, w_ylen};
                    r_year <= r_year + 12'd1;
                    r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!o_status.month_done) begin
                    r_days <= r_days - {11'd0, w_mlen};
                    r_mon  <= r_mon + 4'd1;
                end
            end
            OP_PUBLISH: begin
                r_out_year  <= r_year;
                r_out_month <= r_mon + 4'd1;
                r_out_day   <= r_days[4:0] + 5'd1;
                r_out_hour  <= r_hour;
                r_out_min   <= r_min;
                r_out_sec   <= r_rem[5:0];
            end
            default: begin
            end
        endcase
    end

    assign o_year   = r_out_year;
    assign o_month  = r_out_month;
    assign o_day    = r_out_day;
    assign o_hour   = r_out_hour;
    assign o_minute = r_out_min;
    assign o_second = r_out_sec;

endmodule

`default_nettype wire

FILE: sv/unix_time_to_calendar_date.sv
// Seconds since 1970-01-01 UTC to local calendar date and time of day.
// Input channel: i_valid / o_stall carrying i_epoch_seconds; a transaction
// completes on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carrying year, month, day, hour, minute
// and second; o_valid comes from a register and the fields hold while stalled.
// Config channel: i_cfg_valid / o_cfg_ready writes the signed zone offset in
// hours (i_cfg_data); ready is always high. Write it only while idle.
// Steps: a load, reciprocal-multiply division for days, hours and minutes
// (each a quotient and a remainder step), a walk of years from 1970, a walk
// of months, then the move into the output register.
// One item is in conversion at a time; o_stall is high from acceptance until
// the result moves to the output register. A finished result waits in the
// conversion state while the output register is still held by i_stall.
// Reset (synchronous, i_rst_n low) empties both sides and sets the zone
// offset to +8 hours.
`default_nettype none

module unix_time_to_calendar_date
    import utcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    utcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    utcd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
module tb_top;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_WAIT = 200;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic        o_cfg_ready;

    // Local zone offset as the block should hold it
    logic signed [4:0] zone_hours = 5'sd8;
    t_calendar         dates_due[$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    bit                no_gaps = 1'b0;

    unix_time_to_calendar_date dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_leap(input int y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    // Shift by the zone, clamp at the epoch, then walk years and months from 1970
    function automatic t_calendar to_calendar(input logic [31:0] secs,
                                              input logic signed [4:0] zone);
        longint    shifted;
        longint    days;
        longint    tod;
        int        yr;
        int        mon;
        int        mlen;
        bit        leap;
        t_calendar r;
        shifted = longint'(secs) + longint'(zone) * 3600;
        if (shifted < 0) shifted = 0;
        days = shifted / 86400;
        tod  = shifted % 86400;
        yr = 1970;
        while (days >= (is_leap(yr) ? 366 : 365)) begin
            days -= is_leap(yr) ? 366 : 365;
            yr++;
        end
        leap = is_leap(yr);
        mon = 0;
        forever begin
            case (mon)
                1: mlen = leap ? 29 : 28;
                3, 5, 8, 10: mlen = 30;
                default: mlen = 31;
            endcase
            if (days < mlen || mon >= 11) break;
            days -= mlen;
            mon++;
        end
        r.year   = 12'(yr);
        r.month  = 4'(mon + 1);
        r.day    = 5'(days + 1);
        r.hour   = 5'(tod / 3600);
        r.minute = 6'((tod / 60) % 60);
        r.second = 6'(tod % 60);
        return r;
    endfunction

    task automatic report_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest pending date
    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dates_due.size() == 0) begin
                $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d", $time,
                         o_year, o_month, o_day, o_hour, o_minute, o_second);
                mismatch_count++;
            end else begin
                want = dates_due.pop_front();
                report_field("year", want.year, o_year);
                report_field("month", want.month, o_month);
                report_field("day", want.day, o_day);
                report_field("hour", want.hour, o_hour);
                report_field("minute", want.minute, o_minute);
                report_field("second", want.second, o_second);
            end
        end
    end

    // Stall the result channel for a random number of cycles per result, not at all while no_gaps is set
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // End the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one timestamp after a random gap (none while no_gaps is set) and record its date once taken
    task automatic send_epoch(input logic [31:0] secs);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        dates_due.push_back(to_calendar(secs, zone_hours));
    endtask

    // Drop valid and hold until every pending date has come out
    task automatic wait_results_done();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (dates_due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_zone(input logic signed [4:0] hours);
        wait_results_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hours;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        zone_hours  = hours;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offset left at its reset value of +8 hours
    task automatic test_reset_offset();
        send_epoch(32'd0);
        send_epoch(32'hFFFF_FFFF);
        send_epoch(32'd57599);
        send_epoch(32'd57600);
    endtask

    // Month, leap day and century edges in UTC
    task automatic test_calendar_edges();
        set_zone(5'sd0);
        send_epoch(32'd0);
        send_epoch(32'd59);
        send_epoch(32'd60);
        send_epoch(32'd3599);
        send_epoch(32'd86399);
        send_epoch(32'd86400);
        send_epoch(32'd68169600);
        send_epoch(32'd94607999);
        send_epoch(32'd946684799);
        send_epoch(32'd951782400);
        send_epoch(32'd951868800);
        send_epoch(32'd4107542399);
        send_epoch(32'd4107542400);
        send_epoch(32'hAAAA_AAAA);
        send_epoch(32'h5555_5555);
    endtask

    // Negative offsets that pull early times below the epoch
    task automatic test_clamp_below_epoch();
        set_zone(-5'sd12);
        send_epoch(32'd0);
        send_epoch(32'd43199);
        send_epoch(32'd43200);
        set_zone(-5'sd16);
        send_epoch(32'd57600);
    endtask

    // Largest offsets on the last representable second
    task automatic test_overflow_offsets();
        set_zone(5'sd15);
        send_epoch(32'hFFFF_FFFF);
        set_zone(5'sd14);
        send_epoch(32'hFFFF_FFFF);
    endtask

    // Random timestamps over several offsets, weighted toward day and range edges
    task automatic test_random_phases();
        logic signed [4:0] zones[6];
        logic [31:0]       secs;
        longint            near;
        int                kind;
        zones = '{-5'sd12, 5'sd14, -5'sd16, 5'sd15, 5'sd0, 5'sd8};
        for (int p = 0; p < 6; p++) begin
            if (p == 5) set_zone(5'($urandom_range(0, 31)));
            else set_zone(zones[p]);
            no_gaps = (p == 2);
            for (int i = 0; i < 100; i++) begin
                // hold off once until the block has emptied
                if (p == 3 && i == 50) wait_results_done();
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    secs = $urandom;
                end else if (kind == 4) begin
                    secs = $urandom_range(0, 120000);
                end else if (kind == 5) begin
                    secs = 32'hFFFF_FFFF - $urandom_range(0, 120000);
                end else begin
                    near = longint'($urandom_range(0, 49710)) * 86400
                           - longint'(zone_hours) * 3600 + $urandom_range(0, 4) - 2;
                    secs = near[31:0];
                end
                send_epoch(secs);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_offset();
        test_calendar_edges();
        test_clamp_below_epoch();
        test_overflow_offsets();
        test_random_phases();
        wait_results_done();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (dates_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, dates_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/utcd_pkg.sv
sv/utcd_ctrl.sv
sv/utcd_datapath.sv
sv/unix_time_to_calendar_date.sv
test/tb_top.sv
